FILE: rtl/core/svpwm_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the SVPWM duty and compare pipeline
package svpwm_pkg;

   // Number formats
   localparam int ANGLE_BITS    = 16;
   localparam int FRAC_BITS     = 15;
   localparam int SIN_FRAC      = 30;              // in-sector fraction and sine are Q30
   localparam int M_W           = FRAC_BITS + 1;   // modulation index, one inclusive
   localparam int G_W           = 32;              // sine polynomial accumulator
   localparam int DUTY_W        = 16;
   localparam int PERIOD_W      = 16;
   localparam int SECTOR_COUNT  = 6;

   localparam logic [M_W-1:0] M_ONE = M_W'(1) << FRAC_BITS;

   // Status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_INDEX_HIGH  = 2'd1;
   localparam logic [1:0] STATUS_PERIOD_ZERO = 2'd2;

   typedef struct packed {
      logic               func;
      logic [15:0]        angle;
      logic [15:0]        mod_depth;
      logic signed [15:0] alpha_voltage;
      logic signed [15:0] beta_voltage;
   } svpwm_req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_a;
      logic [DUTY_W-1:0] duty_b;
      logic [DUTY_W-1:0] duty_c;
      logic [2:0]        sector;
      logic [15:0]       compare_a;
      logic [15:0]       compare_b;
      logic [15:0]       compare_c;
      logic [1:0]        status;
   } svpwm_rsp_type;

   // Sector and in-sector fraction, found on entry
   typedef struct packed {
      logic                oob;
      logic [2:0]          sector;
      logic [SIN_FRAC-1:0] u;
   } svpwm_geo_type;

   // After the magnitude unit
   typedef struct packed {
      svpwm_geo_type  geo;
      logic [M_W-1:0] m;
   } svpwm_mag_type;

   // After the sine unit
   typedef struct packed {
      logic           oob;
      logic [2:0]     sector;
      logic [M_W-1:0] m;
      logic [G_W-1:0] g1;
      logic [G_W-1:0] g2;
   } svpwm_sine_type;

   // After the duty unit
   typedef struct packed {
      logic              oob;
      logic [2:0]        sector;
      logic [DUTY_W-1:0] duty_a;
      logic [DUTY_W-1:0] duty_b;
      logic [DUTY_W-1:0] duty_c;
   } svpwm_duty_type;

endpackage

FILE: rtl/core/svpwm_mag.sv
`timescale 1ns / 1ps
// Sector split and modulation magnitude: squares, divide by three, pipelined square root
module svpwm_mag
   import svpwm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  svpwm_req_type in_data,
   output logic          out_valid,
   output svpwm_mag_type out_data
);

   localparam int ANG6_W = ANGLE_BITS + 3;
   localparam int RAD_W  = 2 * FRAC_BITS;
   localparam int REM_W  = FRAC_BITS + 2;
   localparam logic [34:0] CLAMP_LIM = 35'(3) << (2 * FRAC_BITS);
   localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;   // floor(x/3) = (x*RECIP3) >> 33

   typedef struct packed {
      svpwm_geo_type    geo;
      logic             use_root;
      logic [M_W-1:0]   m_fixed;
      logic [RAD_W-1:0] rad;
      logic [REM_W-1:0] rem;
      logic [FRAC_BITS-1:0] root;
   } sq_stage_type;

   // stage 1 registers
   logic                 s1_valid_ff;
   svpwm_geo_type        s1_geo_ff;
   logic                 s1_func_ff;
   logic [15:0]          s1_idx_ff;
   logic [31:0]          s1_sqa_ff;
   logic [31:0]          s1_sqb_ff;
   // stage 2 registers
   logic                 s2_valid_ff;
   svpwm_geo_type        s2_geo_ff;
   logic                 s2_use_root_ff;
   logic [M_W-1:0]       s2_m_fixed_ff;
   logic [31:0]          s2_rad4_ff;
   // divide result and root digit stages
   logic [FRAC_BITS:0]   sq_valid_ff;
   sq_stage_type         sq_ff [FRAC_BITS+1];
   sq_stage_type         sq_in [FRAC_BITS+1];

   logic [ANGLE_BITS-1:0] ang;
   logic [ANG6_W-1:0]     ang6;
   svpwm_geo_type         geo_in;
   logic signed [31:0]    sqa_s;
   logic signed [31:0]    sqb_s;
   logic [32:0]           sum_s;
   logic [34:0]           x4;
   logic                  clamp;
   logic [63:0]           quot;

   // Entry: sector, fraction within the sector, index range check, squares
   always_comb begin
      ang           = ANGLE_BITS'(in_data.angle);
      ang6          = ANG6_W'(ang) * ANG6_W'(SECTOR_COUNT);
      geo_in.oob    = !in_data.func && (32'(in_data.mod_depth) > 32'(M_ONE));
      geo_in.sector = ang6[ANG6_W-1 -: 3];
      geo_in.u      = SIN_FRAC'(ang6[ANGLE_BITS-1:0]) << (SIN_FRAC - ANGLE_BITS);
   end

   assign sqa_s = in_data.alpha_voltage * in_data.alpha_voltage;
   assign sqb_s = in_data.beta_voltage * in_data.beta_voltage;

   // Clamp test on |V|^2 against three quarters
   always_comb begin
      sum_s = 33'(s1_sqa_ff) + 33'(s1_sqb_ff);
      x4    = {sum_s, 2'b00};
      clamp = (x4 >= CLAMP_LIM);
   end

   // Divide by three and one root digit per stage
   always_comb begin
      logic [REM_W+1:0] rem_t;
      logic [REM_W+1:0] trial;
      quot             = (64'(s2_rad4_ff) * 64'(RECIP3)) >> 33;
      sq_in[0].geo      = s2_geo_ff;
      sq_in[0].use_root = s2_use_root_ff;
      sq_in[0].m_fixed  = s2_m_fixed_ff;
      sq_in[0].rad      = RAD_W'(quot);
      sq_in[0].rem      = '0;
      sq_in[0].root     = '0;
      for (int k = 0; k < FRAC_BITS; k++) begin
         sq_in[k+1]     = sq_ff[k];
         rem_t          = {sq_ff[k].rem, sq_ff[k].rad[RAD_W-1 -: 2]};
         trial          = (REM_W+2)'({sq_ff[k].root, 2'b01});
         sq_in[k+1].rad = sq_ff[k].rad << 2;
         if (rem_t >= trial) begin
            sq_in[k+1].rem  = REM_W'(rem_t - trial);
            sq_in[k+1].root = {sq_ff[k].root[FRAC_BITS-2:0], 1'b1};
         end else begin
            sq_in[k+1].rem  = REM_W'(rem_t);
            sq_in[k+1].root = {sq_ff[k].root[FRAC_BITS-2:0], 1'b0};
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sq_valid_ff <= '0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         sq_valid_ff <= {sq_valid_ff[FRAC_BITS-1:0], s2_valid_ff};
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_geo_ff      <= geo_in;
         s1_func_ff     <= in_data.func;
         s1_idx_ff      <= in_data.mod_depth;
         s1_sqa_ff      <= 32'(sqa_s);
         s1_sqb_ff      <= 32'(sqb_s);
         s2_geo_ff      <= s1_geo_ff;
         s2_use_root_ff <= s1_func_ff & ~clamp;
         s2_m_fixed_ff  <= s1_func_ff ? M_ONE : M_W'(s1_idx_ff);
         s2_rad4_ff     <= x4[31:0];
         for (int k = 0; k <= FRAC_BITS; k++) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

   assign out_valid    = sq_valid_ff[FRAC_BITS];
   assign out_data.geo = sq_ff[FRAC_BITS].geo;
   assign out_data.m   = sq_ff[FRAC_BITS].use_root ? M_W'(sq_ff[FRAC_BITS].root)
                                                   : sq_ff[FRAC_BITS].m_fixed;

endmodule

FILE: rtl/core/svpwm_sine.sv
`timescale 1ns / 1ps
// Two-lane odd polynomial for (sqrt3/2)*sin(u*pi/3), one multiply per stage
module svpwm_sine
   import svpwm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  svpwm_mag_type  in_data,
   output logic           out_valid,
   output svpwm_sine_type out_data
);

   localparam int U_W    = SIN_FRAC + 1;
   localparam int P_W    = U_W + G_W;
   localparam int STAGES = 5;
   localparam logic [U_W-1:0] U_ONE = U_W'(1) << SIN_FRAC;
   localparam logic [G_W-1:0] G1 = 32'd973776119;
   localparam logic [G_W-1:0] G3 = 32'd177977511;
   localparam logic [G_W-1:0] G5 = 32'd9758708;
   localparam logic [G_W-1:0] G7 = 32'd254800;

   typedef struct packed {
      logic [U_W-1:0] u;
      logic [U_W-1:0] v;
      logic [G_W-1:0] acc;
   } lane_type;

   logic [STAGES-1:0] vld_ff;
   svpwm_mag_type     it_ff [STAGES];
   svpwm_mag_type     it_in [STAGES];
   lane_type          ln_ff [STAGES][2];
   lane_type          ln_in [STAGES][2];

   // one Horner step: c - (v*acc) >> 30
   function automatic logic [G_W-1:0] horner(input logic [U_W-1:0] v,
                                             input logic [G_W-1:0] acc,
                                             input logic [G_W-1:0] c);
      logic [P_W-1:0] p;
      p      = P_W'(v) * P_W'(acc);
      horner = c - G_W'(p >> SIN_FRAC);
   endfunction

   // lane 0 works on one minus u (T1), lane 1 on u (T2)
   always_comb begin
      logic [2*U_W-1:0] usq;
      logic [P_W-1:0]   ug;
      it_in[0] = in_data;
      for (int s = 1; s < STAGES; s++) begin
         it_in[s] = it_ff[s-1];
      end
      for (int l = 0; l < 2; l++) begin
         ln_in[0][l].u   = (l == 0) ? U_ONE - U_W'(in_data.geo.u) : U_W'(in_data.geo.u);
         usq             = (2*U_W)'(ln_in[0][l].u) * (2*U_W)'(ln_in[0][l].u);
         ln_in[0][l].v   = U_W'(usq >> SIN_FRAC);
         ln_in[0][l].acc = '0;
         for (int s = 1; s < STAGES; s++) begin
            ln_in[s][l] = ln_ff[s-1][l];
         end
         ln_in[1][l].acc = horner(ln_ff[0][l].v, G7, G5);
         ln_in[2][l].acc = horner(ln_ff[1][l].v, ln_ff[1][l].acc, G3);
         ln_in[3][l].acc = horner(ln_ff[2][l].v, ln_ff[2][l].acc, G1);
         ug              = P_W'(ln_ff[3][l].u) * P_W'(ln_ff[3][l].acc);
         ln_in[4][l].acc = G_W'(ug >> SIN_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < STAGES; s++) begin
            it_ff[s]    <= it_in[s];
            ln_ff[s][0] <= ln_in[s][0];
            ln_ff[s][1] <= ln_in[s][1];
         end
      end
   end

   assign out_valid       = vld_ff[STAGES-1];
   assign out_data.oob    = it_ff[STAGES-1].geo.oob;
   assign out_data.sector = it_ff[STAGES-1].geo.sector;
   assign out_data.m      = it_ff[STAGES-1].m;
   assign out_data.g1     = ln_ff[STAGES-1][0].acc;
   assign out_data.g2     = ln_ff[STAGES-1][1].acc;

endmodule

FILE: rtl/core/svpwm_duty.sv
`timescale 1ns / 1ps
// Active and zero vector times, seven-segment phase duties in Q15
module svpwm_duty
   import svpwm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  svpwm_sine_type in_data,
   output logic           out_valid,
   output svpwm_duty_type out_data
);

   localparam int T_W  = 34;                 // Q32 times with headroom
   localparam int MP_W = M_W + G_W + 2;
   localparam logic [T_W-1:0] T_ONE = T_W'(1) << 32;
   localparam logic [T_W:0]   HALF_LSB = (T_W+1)'(1) << (31 - FRAC_BITS);

   typedef struct packed {
      logic           oob;
      logic [2:0]     sector;
      logic [T_W-1:0] t1;
      logic [T_W-1:0] t2;
      logic [T_W-1:0] sum;
      logic [T_W-1:0] t0;
   } time_type;

   logic [2:0]     vld_ff;
   time_type       d0_ff;
   time_type       d0_in;
   time_type       d1_ff;
   time_type       d1_in;
   svpwm_duty_type d2_ff;
   svpwm_duty_type d2_in;

   // Q32 duty to Q15, rounding half up, saturated at one
   function automatic logic [DUTY_W-1:0] to_duty(input logic [T_W-1:0] x);
      logic [T_W:0] r;
      r = ({1'b0, x} + HALF_LSB) >> (32 - FRAC_BITS);
      if (r > (T_W+1)'(M_ONE)) begin
         to_duty = DUTY_W'(M_ONE);
      end else begin
         to_duty = DUTY_W'(r);
      end
   endfunction

   // Times: m * 4g >> FRAC_BITS
   always_comb begin
      logic [MP_W-1:0] p1;
      logic [MP_W-1:0] p2;
      p1           = MP_W'(in_data.m) * MP_W'({in_data.g1, 2'b00});
      p2           = MP_W'(in_data.m) * MP_W'({in_data.g2, 2'b00});
      d0_in.oob    = in_data.oob;
      d0_in.sector = in_data.sector;
      d0_in.t1     = T_W'(p1 >> FRAC_BITS);
      d0_in.t2     = T_W'(p2 >> FRAC_BITS);
      d0_in.sum    = '0;
      d0_in.t0     = '0;
   end

   // Zero time. T1+T2 stays below one for any index up to one, so no rescale.
   always_comb begin
      d1_in     = d0_ff;
      d1_in.sum = d0_ff.t1 + d0_ff.t2;
      d1_in.t0  = (d1_in.sum >= T_ONE) ? '0 : (T_ONE - d1_in.sum) >> 1;
   end

   // Phase on-times by sector
   always_comb begin
      logic [T_W-1:0] hi;
      logic [T_W-1:0] one_a;
      logic [T_W-1:0] one_b;
      logic [T_W-1:0] xa;
      logic [T_W-1:0] xb;
      logic [T_W-1:0] xc;
      hi    = d1_ff.sum + d1_ff.t0;
      one_a = d1_ff.t1 + d1_ff.t0;
      one_b = d1_ff.t2 + d1_ff.t0;
      case (d1_ff.sector)
         3'd0: begin
            xa = hi;       xb = one_b;    xc = d1_ff.t0;
         end
         3'd1: begin
            xa = one_a;    xb = hi;       xc = d1_ff.t0;
         end
         3'd2: begin
            xa = d1_ff.t0; xb = hi;       xc = one_b;
         end
         3'd3: begin
            xa = d1_ff.t0; xb = one_a;    xc = hi;
         end
         3'd4: begin
            xa = one_b;    xb = d1_ff.t0; xc = hi;
         end
         default: begin
            xa = hi;       xb = d1_ff.t0; xc = one_a;
         end
      endcase
      d2_in.oob    = d1_ff.oob;
      d2_in.sector = d1_ff.sector;
      d2_in.duty_a = to_duty(xa);
      d2_in.duty_b = to_duty(xb);
      d2_in.duty_c = to_duty(xc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d0_ff <= d0_in;
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_data  = d2_ff;

endmodule

FILE: rtl/core/svpwm_cmp.sv
`timescale 1ns / 1ps
// Centre-aligned compare values, status and the response register
module svpwm_cmp
   import svpwm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  svpwm_duty_type      in_data,
   input  logic [PERIOD_W-1:0] period,
   output logic                out_valid,
   output svpwm_rsp_type       out_data
);

   localparam int PR_W = DUTY_W + PERIOD_W;
   localparam int TK_W = PR_W - FRAC_BITS;

   logic                c0_valid_ff;
   svpwm_duty_type      c0_ff;
   logic [PERIOD_W-1:0] tick_ff [3];
   logic [PERIOD_W-1:0] tick_in [3];
   logic                rsp_valid_ff;
   svpwm_rsp_type       rsp_ff;
   svpwm_rsp_type       rsp_in;
   logic [DUTY_W-1:0]   duty [3];

   assign duty[0] = in_data.duty_a;
   assign duty[1] = in_data.duty_b;
   assign duty[2] = in_data.duty_c;

   // On-ticks per phase, capped at the period
   always_comb begin
      logic [PR_W-1:0] p;
      logic [TK_W-1:0] t;
      for (int i = 0; i < 3; i++) begin
         p = PR_W'(duty[i]) * PR_W'(period);
         t = TK_W'(p >> FRAC_BITS);
         if (t > TK_W'(period)) begin
            tick_in[i] = period;
         end else begin
            tick_in[i] = PERIOD_W'(t);
         end
      end
   end

   // Compares and status; index out of bounds zeroes all of the response but the status
   always_comb begin
      rsp_in = '0;
      if (c0_ff.oob) begin
         rsp_in.status = STATUS_INDEX_HIGH;
      end else begin
         rsp_in.duty_a = c0_ff.duty_a;
         rsp_in.duty_b = c0_ff.duty_b;
         rsp_in.duty_c = c0_ff.duty_c;
         rsp_in.sector = c0_ff.sector;
         if (period == '0) begin
            rsp_in.status = STATUS_PERIOD_ZERO;
         end else begin
            rsp_in.compare_a = (period - tick_ff[0]) >> 1;
            rsp_in.compare_b = (period - tick_ff[1]) >> 1;
            rsp_in.compare_c = (period - tick_ff[2]) >> 1;
            rsp_in.status    = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         c0_valid_ff  <= in_valid;
         rsp_valid_ff <= c0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c0_ff <= in_data;
         for (int i = 0; i < 3; i++) begin
            tick_ff[i] <= tick_in[i];
         end
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

FILE: rtl/core/svpwm_duty_and_compare.sv
`timescale 1ns / 1ps
// Top level: symmetric seven-segment SVPWM duty and compare generator
//
//   Channel   Ports                                  Direction  Moves
//   req       req_valid, req_ready, req_data         in         one angle/voltage request
//   rsp       rsp_valid, rsp_ready, rsp_data         out        duties, sector, compares, status
//   csr       csr_write_enable, csr_write_data       in         timer period write
//
// One request enters per cycle unless rsp_ready low holds the pipeline; each request passes
// through square and divide-by-three stages, 15 root digit stages, 5 sine stages, 3 duty
// stages and 2 compare stages ending in the response register.
// Synchronous reset clears the valid bits and sets the timer period to zero.
// A response held by rsp_ready low freezes the whole pipeline; nothing is lost.
module svpwm_duty_and_compare
   import svpwm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  svpwm_req_type       req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output svpwm_rsp_type       rsp_data,
   input  logic                csr_write_enable,
   input  logic [PERIOD_W-1:0] csr_write_data
);

   logic [PERIOD_W-1:0] period_ff;
   logic                en;
   logic                mag_valid;
   svpwm_mag_type       mag_data;
   logic                sine_valid;
   svpwm_sine_type      sine_data;
   logic                duty_valid;
   svpwm_duty_type      duty_data;

   // Pipeline moves unless a finished response is waiting
   assign en        = ~rsp_valid | rsp_ready;
   assign req_ready = en;

   // Timer period register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
      end else if (csr_write_enable) begin
         period_ff <= csr_write_data;
      end
   end

   svpwm_mag u_mag (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (mag_valid),
      .out_data  (mag_data)
   );

   svpwm_sine u_sine (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mag_valid),
      .in_data   (mag_data),
      .out_valid (sine_valid),
      .out_data  (sine_data)
   );

   svpwm_duty u_duty (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sine_valid),
      .in_data   (sine_data),
      .out_valid (duty_valid),
      .out_data  (duty_data)
   );

   svpwm_cmp u_cmp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (duty_valid),
      .in_data   (duty_data),
      .period    (period_ff),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

FILE: bench/svpwm_duty_and_compare_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the SVPWM duty and compare generator
module svpwm_duty_and_compare_tb;
   import svpwm_pkg::*;

   localparam longint unsigned TURN_FRAC = 64'd1 << 30;
   localparam longint unsigned Q32_FULL  = 64'd1 << 32;
   localparam int              PIPE_LAT  = 28;
   localparam int              CYCLE_CAP = 400000;

   // Scoreboard: expected responses computed from accepted requests
   class duty_scoreboard;
      svpwm_rsp_type pending_rsp[$];
      int            fault_count;
      logic [15:0]   period_reg;

      function new();
         fault_count = 0;
         period_reg  = '0;
      endfunction

      // (sqrt3/2)*sin(u*pi/3), Q30 in and out
      function longint unsigned phase_sine(longint unsigned u);
         longint unsigned v, acc;
         v   = (u * u) >> 30;
         acc = 64'd9758708 - ((v * 64'd254800) >> 30);
         acc = 64'd177977511 - ((v * acc) >> 30);
         acc = 64'd973776119 - ((v * acc) >> 30);
         return (u * acc) >> 30;
      endfunction

      function longint unsigned isqrt(longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function longint unsigned q32_to_duty(longint unsigned x);
         longint unsigned d;
         d = (x + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
         return (d > (64'd1 << FRAC_BITS)) ? (64'd1 << FRAC_BITS) : d;
      endfunction

      function svpwm_rsp_type compute_duties(svpwm_req_type rq);
         svpwm_rsp_type   rs;
         longint unsigned one, m, sec, r, u, t1, t2, sum, t0, s, tk;
         longint unsigned x[3];
         longint unsigned d[3];
         longint          a, b;
         one = 64'd1 << FRAC_BITS;
         rs  = '0;
         if (rq.func == 1'b0) begin
            m = rq.mod_depth;
            if (m > one) begin
               rs.status = STATUS_INDEX_HIGH;
               return rs;
            end
         end else begin
            a = rq.alpha_voltage;
            b = rq.beta_voltage;
            s = a * a + b * b;
            if (4 * s >= 3 * one * one) m = one;
            else m = isqrt((4 * s) / 3);
         end
         sec = (longint'(rq.angle) * 6) >> ANGLE_BITS;
         r   = longint'(rq.angle) * 6 - (sec << ANGLE_BITS);
         u   = r << (30 - ANGLE_BITS);
         t1  = (m * (phase_sine(TURN_FRAC - u) << 2)) >> FRAC_BITS;
         t2  = (m * (phase_sine(u) << 2)) >> FRAC_BITS;
         sum = t1 + t2;
         if (sum > Q32_FULL) begin
            t1  = (t1 << 32) / sum;
            t2  = (t2 << 32) / sum;
            sum = t1 + t2;
         end
         t0 = (sum >= Q32_FULL) ? 0 : (Q32_FULL - sum) >> 1;
         case (sec)
            0: begin x[0] = sum + t0; x[1] = t2 + t0;  x[2] = t0;       end
            1: begin x[0] = t1 + t0;  x[1] = sum + t0; x[2] = t0;       end
            2: begin x[0] = t0;       x[1] = sum + t0; x[2] = t2 + t0;  end
            3: begin x[0] = t0;       x[1] = t1 + t0;  x[2] = sum + t0; end
            4: begin x[0] = t2 + t0;  x[1] = t0;       x[2] = sum + t0; end
            default: begin x[0] = sum + t0; x[1] = t0; x[2] = t1 + t0;  end
         endcase
         for (int i = 0; i < 3; i++) d[i] = q32_to_duty(x[i]);
         rs.duty_a = d[0][15:0];
         rs.duty_b = d[1][15:0];
         rs.duty_c = d[2][15:0];
         rs.sector = sec[2:0];
         if (period_reg == 0) begin
            rs.status = STATUS_PERIOD_ZERO;
            return rs;
         end
         for (int i = 0; i < 3; i++) begin
            tk = (d[i] * period_reg) >> FRAC_BITS;
            if (tk > period_reg) tk = period_reg;
            d[i] = (period_reg - tk) >> 1;
         end
         rs.compare_a = d[0][15:0];
         rs.compare_b = d[1][15:0];
         rs.compare_c = d[2][15:0];
         rs.status    = STATUS_OK;
         return rs;
      endfunction

      function void note_request(svpwm_req_type rq);
         pending_rsp.push_back(compute_duties(rq));
      endfunction

      function void check_response(svpwm_rsp_type got);
         svpwm_rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response %h", got);
            fault_count++;
            return;
         end
         want = pending_rsp.pop_front();
         if (got.duty_a !== want.duty_a) begin
            $error("duty_a exp %0d got %0d", want.duty_a, got.duty_a); fault_count++;
         end
         if (got.duty_b !== want.duty_b) begin
            $error("duty_b exp %0d got %0d", want.duty_b, got.duty_b); fault_count++;
         end
         if (got.duty_c !== want.duty_c) begin
            $error("duty_c exp %0d got %0d", want.duty_c, got.duty_c); fault_count++;
         end
         if (got.sector !== want.sector) begin
            $error("sector exp %0d got %0d", want.sector, got.sector); fault_count++;
         end
         if (got.compare_a !== want.compare_a) begin
            $error("compare_a exp %0d got %0d", want.compare_a, got.compare_a);
            fault_count++;
         end
         if (got.compare_b !== want.compare_b) begin
            $error("compare_b exp %0d got %0d", want.compare_b, got.compare_b);
            fault_count++;
         end
         if (got.compare_c !== want.compare_c) begin
            $error("compare_c exp %0d got %0d", want.compare_c, got.compare_c);
            fault_count++;
         end
         if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); fault_count++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   svpwm_req_type       req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   svpwm_rsp_type       rsp_data;
   logic                csr_write_enable = 1'b0;
   logic [PERIOD_W-1:0] csr_write_data = '0;

   duty_scoreboard board = new();
   int              cycle_count = 0;
   bit              quiet_sink = 1'b0;

   svpwm_duty_and_compare dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #10 clock = ~clock;

   // Response sampling and timeout watch
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
      if (cycle_count > CYCLE_CAP) begin
         $display("svpwm_duty_and_compare regression: fail");
         $finish;
      end
   end

   // Sink: random stall per response, with no-stall stretches
   initial begin : sink
      int gap;
      @(negedge clock);
      forever begin
         gap = quiet_sink ? 0 : $urandom_range(0, 19);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
         @(negedge clock);
      end
   end

   // Send one request with an optional random idle gap in front
   task automatic send_request(svpwm_req_type rq, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      board.note_request(rq);
      @(negedge clock);
   endtask

   // Wait for the pipeline to drain, then write the period
   task automatic write_period(logic [15:0] p);
      req_valid <= 1'b0;
      while (board.pending_rsp.size() != 0) @(negedge clock);
      repeat (PIPE_LAT + 4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= p;
      board.period_reg = p;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic svpwm_req_type random_request();
      svpwm_req_type rq;
      rq.func  = 1'($urandom_range(0, 1));
      rq.angle = 16'($urandom);
      case ($urandom_range(0, 5))
         0: rq.mod_depth = 16'($urandom);
         1: rq.mod_depth = M_ONE;
         default: rq.mod_depth = 16'($urandom_range(0, 32768));
      endcase
      rq.alpha_voltage = 16'($urandom);
      rq.beta_voltage  = 16'($urandom);
      if ($urandom_range(0, 2) == 0) begin
         rq.alpha_voltage = $signed(16'($urandom_range(0, 40000))) >>> 1;
         rq.beta_voltage  = $signed(16'($urandom_range(0, 40000))) >>> 1;
      end
      return rq;
   endfunction

   initial begin : stimulus
      svpwm_req_type rq;
      logic [15:0]   periods[6];
      periods = '{16'd1, 16'd65535, 16'd2, 16'd1000, 16'd40000, 16'd0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero period after reset, then full scale period
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1) write_period(16'hFFFF);
         rq = '0;
         send_request(rq, 1'b0);
         rq.mod_depth = M_ONE;
         for (int k = 0; k < 7; k++) begin
            rq.angle = (k == 6) ? 16'hFFFF : 16'(k * 10923);
            send_request(rq, 1'b1);
         end
         rq.mod_depth = 16'h8001;            // index just above one
         send_request(rq, 1'b0);
         rq.mod_depth = 16'hFFFF;
         send_request(rq, 1'b0);
         rq.func = 1'b1;
         rq.alpha_voltage = 16'sh8000;        // beyond the clamp circle
         rq.beta_voltage  = 16'sh8000;
         send_request(rq, 1'b0);
         rq.alpha_voltage = 16'sh7FFF;
         rq.beta_voltage  = 16'sh0000;
         send_request(rq, 1'b1);
         rq.alpha_voltage = 16'sh0000;
         send_request(rq, 1'b0);
      end

      // Random phases over several periods
      for (int ph = 0; ph < 6; ph++) begin
         write_period(ph == 5 ? 16'($urandom) : periods[ph]);
         quiet_sink = (ph == 2);
         for (int n = 0; n < 200; n++) send_request(random_request(), ph == 2);
      end
      write_period(16'd0);
      for (int n = 0; n < 30; n++) send_request(random_request(), 1'b0);
      req_valid <= 1'b0;

      while (board.pending_rsp.size() != 0) @(negedge clock);
      repeat (PIPE_LAT + 4) @(negedge clock);
      if (board.fault_count == 0) begin
         $display("svpwm_duty_and_compare regression: pass");
      end else begin
         $display("svpwm_duty_and_compare regression: fail");
      end
      $finish;
   end
endmodule

FILE: sim.f
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_mag.sv
rtl/core/svpwm_sine.sv
rtl/core/svpwm_duty.sv
rtl/core/svpwm_cmp.sv
rtl/core/svpwm_duty_and_compare.sv
bench/svpwm_duty_and_compare_tb.sv
